// ----- design/assert_macros.svh -----
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is low
`define ASSERT_NEXT(label, clk, ante, rst_n, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, also checked through reset
`define ASSERT_NEXT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/tcpg_pkg.sv -----
package tcpg_pkg;

    // function codes of an input request
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    // register indexes on the configuration port
    localparam logic [2:0] REG_CELL_WIDTH  = 3'd0;
    localparam logic [2:0] REG_CELL_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FONT_SIZE   = 3'd2;
    localparam logic [2:0] REG_CUR_SHOW    = 3'd3;
    localparam logic [2:0] REG_CUR_INSERT  = 3'd4;
    localparam logic [2:0] REG_CUR_ROW     = 3'd5;
    localparam logic [2:0] REG_CUR_COL     = 3'd6;

    localparam logic [23:0] DIM_MASK    = 24'h7F7F7F;
    localparam logic [3:0]  MAX_WIDTH   = 4'd8;
    localparam logic [2:0]  MSB_INDEX   = 3'd7;
    localparam logic [5:0]  CURSOR_ROWS = 6'd2;
    localparam int          QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [3:0]  cell_width;
        logic [4:0]  cell_height;
        logic [12:0] font_size;
        logic        cur_show;
        logic        cur_insert;
        logic [6:0]  cur_row;
        logic [7:0]  cur_col;
    } t_cfg;

    // one classified cell scanline, ready for pixel output
    typedef struct packed {
        logic [7:0]  bits;
        logic [23:0] base;
        logic [23:0] gcol;
        logic [10:0] px0;
        logic [10:0] py;
        logic [3:0]  w;
    } t_cell;

endpackage

// ----- design/tcpg_ram.sv -----
module tcpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/tcpg_front.sv -----
module tcpg_front import tcpg_pkg::*; #(
    parameter int FONT_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [11:0] i_font_addr,
    input  logic [7:0]  i_font_byte,
    input  logic [7:0]  i_cell_col,
    input  logic [6:0]  i_cell_row,
    input  logic [3:0]  i_scanline,
    input  logic [7:0]  i_char_code,
    input  logic [23:0] i_fore_colour,
    input  logic [23:0] i_back_colour,
    input  logic [3:0]  i_attr_flags,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cell       o_cell
);

    localparam int AW = $clog2(FONT_BYTES);
    localparam logic [16:0] FONT_LIM = 17'(FONT_BYTES);

    // stage a: accepted request, font address
    logic        r_a_valid;
    logic        r_a_func;
    logic [11:0] r_a_addr;
    logic [7:0]  r_a_byte;
    logic [7:0]  r_a_col;
    logic [6:0]  r_a_row;
    logic [3:0]  r_a_scan;
    logic [7:0]  r_a_code;
    logic [23:0] r_a_fore;
    logic [23:0] r_a_back;
    logic [3:0]  r_a_attrs;

    // stage b: font byte back from the store, classification
    logic        r_b_valid;
    logic        r_b_oob;
    logic [7:0]  r_b_col;
    logic [6:0]  r_b_row;
    logic [3:0]  r_b_scan;
    logic [23:0] r_b_fore;
    logic [23:0] r_b_back;
    logic [3:0]  r_b_attrs;

    logic        a_is_load;
    logic        a_leave;
    logic        a_take;
    logic        move_ab;
    logic        b_drop;
    logic        b_done;
    logic [12:0] idx;
    logic        idx_oob;
    logic        wr_en;
    logic        rd_en;
    logic [7:0]  rd_data;
    logic [7:0]  raw_bits;
    logic [3:0]  w;
    logic        at_cursor;
    logic        cursor_here;
    logic        ul_row;
    logic [23:0] ucol;
    logic [23:0] sel_col;
    logic [23:0] base;
    logic [23:0] gcol;
    logic [11:0] px_prod;
    logic [12:0] py_sum;

    assign a_is_load  = (r_a_func == FUNC_LOAD);
    assign b_drop     = (w == 4'd0);
    assign b_done     = r_b_valid && (b_drop || !i_q_full);
    assign move_ab    = !r_b_valid || b_done;
    assign a_leave    = r_a_valid && (a_is_load || move_ab);
    assign o_in_stall = r_a_valid && !a_leave;
    assign a_take     = i_in_valid && !o_in_stall;

    assign idx     = 13'(r_a_code) * 13'(i_cfg.cell_height) + 13'(r_a_scan);
    assign idx_oob = (idx >= i_cfg.font_size) || (17'(idx) >= FONT_LIM);
    assign wr_en   = r_a_valid && a_is_load && (17'(r_a_addr) < FONT_LIM);
    assign rd_en   = r_a_valid && !a_is_load && move_ab;

    tcpg_ram #(
        .WIDTH (8),
        .DEPTH (FONT_BYTES)
    ) u_font (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(r_a_addr)),
        .i_wr_data (r_a_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (AW'(idx)),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_take) begin
                r_a_valid <= 1'b1;
            end else if (a_leave) begin
                r_a_valid <= 1'b0;
            end
            if (move_ab) begin
                r_b_valid <= rd_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_take) begin
            r_a_func  <= i_func;
            r_a_addr  <= i_font_addr;
            r_a_byte  <= i_font_byte;
            r_a_col   <= i_cell_col;
            r_a_row   <= i_cell_row;
            r_a_scan  <= i_scanline;
            r_a_code  <= i_char_code;
            r_a_fore  <= i_fore_colour;
            r_a_back  <= i_back_colour;
            r_a_attrs <= i_attr_flags;
        end
        if (rd_en) begin
            r_b_oob   <= idx_oob;
            r_b_col   <= r_a_col;
            r_b_row   <= r_a_row;
            r_b_scan  <= r_a_scan;
            r_b_fore  <= r_a_fore;
            r_b_back  <= r_a_back;
            r_b_attrs <= r_a_attrs;
        end
    end

    always_comb begin
        w = (i_cfg.cell_width > MAX_WIDTH) ? MAX_WIDTH : i_cfg.cell_width;

        raw_bits = r_b_oob ? 8'd0 : rd_data;
        if (r_b_attrs[2]) begin
            raw_bits = raw_bits | (raw_bits >> 1);
        end

        at_cursor   = i_cfg.cur_show && (r_b_row == i_cfg.cur_row)
                      && (r_b_col == i_cfg.cur_col);
        cursor_here = at_cursor && (i_cfg.cur_insert
                      || (6'(r_b_scan) + CURSOR_ROWS >= 6'(i_cfg.cell_height)));
        ul_row      = r_b_attrs[3] && ((5'(r_b_scan) + 5'd1) == i_cfg.cell_height);

        sel_col = r_b_attrs[0] ? r_b_back : r_b_fore;
        ucol    = r_b_attrs[1] ? ((sel_col >> 1) & DIM_MASK) : sel_col;
        base    = (cursor_here || r_b_attrs[0]) ? r_b_fore : r_b_back;
        gcol    = (at_cursor && i_cfg.cur_insert) ? r_b_back : ucol;

        // underline row overrides every pixel
        if (ul_row) begin
            base = ucol;
            gcol = ucol;
        end

        px_prod = 12'(r_b_col) * 12'(w);
        py_sum  = 13'(r_b_row) * 13'(i_cfg.cell_height) + 13'(r_b_scan);

        o_cell.bits = raw_bits;
        o_cell.base = base;
        o_cell.gcol = gcol;
        o_cell.px0  = px_prod[10:0];
        o_cell.py   = py_sum[10:0];
        o_cell.w    = w;
    end

    assign o_push = r_b_valid && !b_drop && !i_q_full;

endmodule

// ----- design/tcpg_queue.sv -----
module tcpg_queue import tcpg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cell i_cell,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_cell o_head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cell         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= PW'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= PW'(r_rd_ptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cell;
        end
    end

endmodule

// ----- design/tcpg_back.sv -----
module tcpg_back import tcpg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cell       i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_pixel_x,
    output logic [10:0] o_pixel_y,
    output logic [23:0] o_pixel_colour,
    output logic        o_last
);

    logic [2:0]  r_gx;
    logic        r_out_valid;
    logic [10:0] r_pixel_x;
    logic [10:0] r_pixel_y;
    logic [23:0] r_pixel_colour;
    logic        r_last;

    logic        emit;
    logic        last;
    logic        bit_set;

    assign emit    = i_q_valid && (!r_out_valid || !i_out_stall);
    assign last    = ((4'(r_gx) + 4'd1) == i_head.w);
    assign bit_set = i_head.bits[MSB_INDEX - r_gx];
    assign o_pop   = emit && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gx        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_gx <= last ? 3'd0 : 3'(r_gx + 1'b1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pixel_x      <= i_head.px0 + 11'(r_gx);
            r_pixel_y      <= i_head.py;
            r_pixel_colour <= bit_set ? i_head.gcol : i_head.base;
            r_last         <= last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_x      = r_pixel_x;
    assign o_pixel_y      = r_pixel_y;
    assign o_pixel_colour = r_pixel_colour;
    assign o_last         = r_last;

endmodule

// ----- design/text_cell_pixel_generator_core.sv -----
// a render request goes through stage a, stage b, the queue and the pixel output register
// throughput: loads one per cycle; renders one per cycle while the 4-entry queue has room,
//   else as fast as the back end drains it, one pixel per cycle while the output is not stalled
// font loads give no pixels
// reset (synchronous, active low) empties the pipeline and queue and restores the
//   register defaults; font store contents are undefined until written, no clear pass
module text_cell_pixel_generator_core import tcpg_pkg::*; #(
    parameter int FONT_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [11:0] i_font_addr,
    input  logic [7:0]  i_font_byte,
    input  logic [7:0]  i_cell_col,
    input  logic [6:0]  i_cell_row,
    input  logic [3:0]  i_scanline,
    input  logic [7:0]  i_char_code,
    input  logic [23:0] i_fore_colour,
    input  logic [23:0] i_back_colour,
    input  logic [3:0]  i_attr_flags,
    // pixel channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_pixel_x,
    output logic [10:0] o_pixel_y,
    output logic [23:0] o_pixel_colour,
    output logic        o_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    t_cfg  r_cfg;
    logic  cfg_wr;

    // front to queue
    logic  push;
    t_cell push_cell;
    logic  q_full;

    // queue to back
    logic  q_valid;
    t_cell head;
    logic  pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // register writes, word address in paddr[4:2]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_width  <= 4'd8;
            r_cfg.cell_height <= 5'd16;
            r_cfg.font_size   <= 13'd4096;
            r_cfg.cur_show    <= 1'b0;
            r_cfg.cur_insert  <= 1'b0;
            r_cfg.cur_row     <= 7'd0;
            r_cfg.cur_col     <= 8'd0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_CELL_WIDTH:  r_cfg.cell_width  <= pwdata[3:0];
                REG_CELL_HEIGHT: r_cfg.cell_height <= pwdata[4:0];
                REG_FONT_SIZE:   r_cfg.font_size   <= pwdata[12:0];
                REG_CUR_SHOW:    r_cfg.cur_show    <= pwdata[0];
                REG_CUR_INSERT:  r_cfg.cur_insert  <= pwdata[0];
                REG_CUR_ROW:     r_cfg.cur_row     <= pwdata[6:0];
                REG_CUR_COL:     r_cfg.cur_col     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register reads, unused low address bits ignored
    always_comb begin
        case (paddr[4:2])
            REG_CELL_WIDTH:  prdata = 32'(r_cfg.cell_width);
            REG_CELL_HEIGHT: prdata = 32'(r_cfg.cell_height);
            REG_FONT_SIZE:   prdata = 32'(r_cfg.font_size);
            REG_CUR_SHOW:    prdata = 32'(r_cfg.cur_show);
            REG_CUR_INSERT:  prdata = 32'(r_cfg.cur_insert);
            REG_CUR_ROW:     prdata = 32'(r_cfg.cur_row);
            REG_CUR_COL:     prdata = 32'(r_cfg.cur_col);
            default:         prdata = 32'd0;
        endcase
    end

    // front: takes requests, writes or reads the font store, classifies each cell
    tcpg_front #(
        .FONT_BYTES (FONT_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_font_addr   (i_font_addr),
        .i_font_byte   (i_font_byte),
        .i_cell_col    (i_cell_col),
        .i_cell_row    (i_cell_row),
        .i_scanline    (i_scanline),
        .i_char_code   (i_char_code),
        .i_fore_colour (i_fore_colour),
        .i_back_colour (i_back_colour),
        .i_attr_flags  (i_attr_flags),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cell        (push_cell)
    );

    // short queue so the front keeps taking requests while pixels drain
    tcpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cell  (push_cell),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head)
    );

    // back: walks the cell one pixel per cycle, while the output is not stalled, into the output register
    tcpg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_colour (o_pixel_colour),
        .o_last         (o_last)
    );

endmodule

// ----- design/tcpg_checker.sv -----
`include "assert_macros.svh"

module tcpg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_stall,
    input logic        o_out_valid,
    input logic [10:0] o_pixel_x,
    input logic [10:0] o_pixel_y,
    input logic [23:0] o_pixel_colour,
    input logic        o_last
);

    // reset empties the pixel output
    `ASSERT_NEXT_ALL(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

    // a stalled pixel holds its x, colour and last flag
    `ASSERT_NEXT(a_out_hold, i_clk, o_out_valid && i_out_stall, i_rst_n, o_out_valid && $stable(o_pixel_x) && $stable(o_pixel_colour) && $stable(o_last))

    // pixels of one scanline come out left to right with no gap in x
    `ASSERT_NEXT(a_x_step, i_clk, o_out_valid && !i_out_stall && !o_last, i_rst_n, !o_out_valid || (o_pixel_x == 11'($past(o_pixel_x) + 11'd1)))

    // a scanline stays on one pixel row
    `ASSERT_NEXT(a_y_same, i_clk, o_out_valid && !i_out_stall && !o_last, i_rst_n, !o_out_valid || $stable(o_pixel_y))

endmodule

bind text_cell_pixel_generator_core tcpg_checker u_tcpg_checker (.*);
